/* rtl/core/sparse_chunked_bit_grid_assert.svh */
// Assertion macros for the checker of the sparse chunked bit grid.
// Needs nothing else; each file that asserts includes it by name.
`ifndef SPARSE_CHUNKED_BIT_GRID_ASSERT_SVH
`define SPARSE_CHUNKED_BIT_GRID_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SCBG_CHECK_NOW(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SCBG_CHECK_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/scbg_pkg.sv */
// Shared constants, command codes and control structs of the sparse chunked bit grid.
// Depends on nothing; the interfaces, the directory, the top level and the bench import it.
package scbg_pkg;

  localparam int CHUNK_ENTRIES_DEF = 16;
  localparam int CHUNK_SIDE_DEF    = 1 << 5;
  localparam int COORD_BITS_DEF    = 16;

  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CULL  = 2'd2;

  // Directory update requested by the sequencer.
  typedef struct packed {
    logic alloc;  // claim the lowest free entry for the looked-up key
    logic drop;   // free the entry at the given index if it is present
  } dir_op_t;

  // Directory lookup result.
  typedef struct packed {
    logic hit;       // key present
    logic has_free;  // at least one entry is free
  } dir_stat_t;

endpackage

/* rtl/core/scbg_req_if.sv */
// Request channel of the sparse chunked bit grid: valid/ready plus one command item.
// Depends on scbg_pkg.
interface scbg_req_if #(
  parameter int COORD_BITS = scbg_pkg::COORD_BITS_DEF
);
  import scbg_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             cmd;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic                         set_value;

  modport source (output valid, cmd, x_coord, y_coord, set_value, input ready);
  modport sink   (input valid, cmd, x_coord, y_coord, set_value, output ready);

endinterface

/* rtl/core/scbg_rsp_if.sv */
// Response channel of the sparse chunked bit grid: valid/ready plus one result item.
// Depends on scbg_pkg.
interface scbg_rsp_if #(
  parameter int CHUNK_ENTRIES = scbg_pkg::CHUNK_ENTRIES_DEF
);
  import scbg_pkg::*;

  localparam int COUNT_W = $clog2(CHUNK_ENTRIES + 1);

  logic               valid;
  logic               ready;
  logic               cell_value;
  logic               status;
  logic [COUNT_W-1:0] chunk_count;

  modport source (output valid, cell_value, status, chunk_count, input ready);
  modport sink   (input valid, cell_value, status, chunk_count, output ready);

endinterface

/* rtl/core/scbg_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module scbg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/core/scbg_dir.sv */
// Chunk directory: present flags and keys in flip-flops, parallel key match,
// lowest-free search and the running count of present entries. Depends on scbg_pkg.
module scbg_dir #(
  parameter int CHUNK_ENTRIES = scbg_pkg::CHUNK_ENTRIES_DEF,
  parameter int KEY_W         = 22,
  localparam int IDX_W        = (CHUNK_ENTRIES > 1) ? $clog2(CHUNK_ENTRIES) : 1,
  localparam int COUNT_W      = $clog2(CHUNK_ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [KEY_W-1:0]    key,
  input  scbg_pkg::dir_op_t   op,
  input  logic [IDX_W-1:0]    drop_idx,
  output scbg_pkg::dir_stat_t stat,
  output logic [IDX_W-1:0]    hit_idx,
  output logic [IDX_W-1:0]    free_idx,
  output logic [COUNT_W-1:0]  present
);
  import scbg_pkg::*;

  logic [CHUNK_ENTRIES-1:0] valid;
  logic [KEY_W-1:0]         keys [CHUNK_ENTRIES];

  // Lowest index wins in both searches; at most one entry can match a key.
  always_comb begin
    stat     = '0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = CHUNK_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == key) begin
        stat.hit = 1'b1;
        hit_idx  = IDX_W'(i);
      end
      if (!valid[i]) begin
        stat.has_free = 1'b1;
        free_idx      = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= CHUNK_ENTRIES'(1);
      present <= COUNT_W'(1);
      for (int i = 0; i < CHUNK_ENTRIES; i++) begin
        keys[i] <= '0;
      end
    end else if (op.alloc && stat.has_free) begin
      valid[free_idx] <= 1'b1;
      keys[free_idx]  <= key;
      present         <= present + COUNT_W'(1);
    end else if (op.drop && valid[drop_idx]) begin
      valid[drop_idx] <= 1'b0;
      present         <= present - COUNT_W'(1);
    end
  end

endmodule

/* rtl/core/sparse_chunked_bit_grid.sv */
// Top level of the sparse chunked bit grid: sequencer, bitmap and live-count memories.
// Depends on scbg_pkg, scbg_req_if, scbg_rsp_if, scbg_ram and scbg_dir.
//
// The block holds a large, mostly empty two-dimensional bit grid as square chunks of
// CHUNK_SIDE by CHUNK_SIDE cells. A directory of CHUNK_ENTRIES flip-flop entries maps
// a chunk key (the coordinates shifted right arithmetically by log2(CHUNK_SIDE)) to
// a slot; the bitmaps live in one RAM row per cell row and the live-cell counts in a
// second, small RAM. In the accept cycle of a read or write item the directory is
// matched and both RAMs are read; in the access state the bit is taken and, once
// the output register is free, a write that changes it writes the row and the count
// back through each RAM's single port. A cull item walks the count RAM one entry
// per cycle. After reset the block runs a clearing pass over the count RAM and all
// CHUNK_ENTRIES * CHUNK_SIDE bitmap rows (512 with the defaults), and accepts
// no item until it is done. A freed entry always has an empty bitmap and a zero
// count, so allocation needs no clearing of its own. CHUNK_SIDE must be a power of
// two. The result sits in an output register, so the next item can be accepted
// while the previous result still waits to be taken.
module sparse_chunked_bit_grid #(
  parameter int CHUNK_ENTRIES = scbg_pkg::CHUNK_ENTRIES_DEF,
  parameter int CHUNK_SIDE    = scbg_pkg::CHUNK_SIDE_DEF,
  parameter int COORD_BITS    = scbg_pkg::COORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  scbg_req_if.sink  req,
  scbg_rsp_if.source rsp
);
  import scbg_pkg::*;

  localparam int LOC_W   = $clog2(CHUNK_SIDE);
  localparam int CHK_W   = COORD_BITS - LOC_W;
  localparam int KEY_W   = 2 * CHK_W;
  localparam int IDX_W   = (CHUNK_ENTRIES > 1) ? $clog2(CHUNK_ENTRIES) : 1;
  localparam int ROWS    = CHUNK_ENTRIES * CHUNK_SIDE;
  localparam int ROW_AW  = $clog2(ROWS);
  localparam int LIVE_W  = $clog2(CHUNK_SIDE * CHUNK_SIDE + 1);
  localparam int COUNT_W = $clog2(CHUNK_ENTRIES + 1);

  // Sequencer states.
  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_ACCESS = 2'd2;
  localparam logic [1:0] ST_CULL   = 2'd3;

  logic [1:0] state;
  logic       accept;
  logic       fin;

  // Coordinate split: floor division by a power of two is an arithmetic shift,
  // the floor remainder is the low bits.
  logic [CHK_W-1:0] cx;
  logic [CHK_W-1:0] cy;
  logic [LOC_W-1:0] lx;
  logic [LOC_W-1:0] ly;
  logic [KEY_W-1:0] key;

  // Directory interface.
  dir_op_t            dop;
  dir_stat_t          dstat;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   e_sel;
  logic [COUNT_W-1:0] present;

  // Decode of the item being accepted.
  logic req_use;
  logic req_full;
  logic req_alloc;

  // The item in flight.
  logic [CMD_W-1:0]  op_cmd;
  logic              op_use;
  logic              op_full;
  logic              op_val;
  logic [IDX_W-1:0]  op_idx;
  logic [LOC_W-1:0]  op_lx;
  logic [ROW_AW-1:0] op_row;

  // Clearing pass and cull walk.
  logic [ROW_AW-1:0]  clr_cnt;
  logic [COUNT_W-1:0] walk;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;

  // Memory ports.
  logic                  row_we;
  logic                  row_re;
  logic [ROW_AW-1:0]     row_addr;
  logic [CHUNK_SIDE-1:0] row_wd;
  logic [CHUNK_SIDE-1:0] row_q;
  logic                  live_we;
  logic                  live_re;
  logic [IDX_W-1:0]      live_addr;
  logic [LIVE_W-1:0]     live_wd;
  logic [LIVE_W-1:0]     live_q;

  // Bit update.
  logic                  row_old;
  logic [CHUNK_SIDE-1:0] row_new;
  logic [LIVE_W-1:0]     live_new;
  logic                  do_write;

  // Output register.
  logic               out_valid;
  logic               out_cell;
  logic               out_status;
  logic [COUNT_W-1:0] out_count;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign fin       = (state == ST_ACCESS) && (!out_valid || rsp.ready);

  assign cx  = req.x_coord[COORD_BITS-1:LOC_W];
  assign cy  = req.y_coord[COORD_BITS-1:LOC_W];
  assign lx  = req.x_coord[LOC_W-1:0];
  assign ly  = req.y_coord[LOC_W-1:0];
  assign key = {cx, cy};

  assign e_sel = dstat.hit ? hit_idx : free_idx;

  // A write of one to an absent chunk claims a slot; with none free it is dropped
  // and flagged. A write of zero to an absent chunk and a read of one do nothing.
  always_comb begin
    req_use   = 1'b0;
    req_full  = 1'b0;
    req_alloc = 1'b0;
    case (req.cmd)
      CMD_READ: begin
        req_use = dstat.hit;
      end
      CMD_WRITE: begin
        if (dstat.hit) begin
          req_use = 1'b1;
        end else if (req.set_value) begin
          if (dstat.has_free) begin
            req_alloc = 1'b1;
            req_use   = 1'b1;
          end else begin
            req_full = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // During a cull an entry is freed when its count, read in the previous cycle, is zero.
  assign dop.alloc = accept && req_alloc;
  assign dop.drop  = (state == ST_CULL) && pend && (live_q == '0);

  scbg_dir #(
    .CHUNK_ENTRIES (CHUNK_ENTRIES),
    .KEY_W         (KEY_W)
  ) u_dir (
    .clk      (clk),
    .rst      (rst),
    .key      (key),
    .op       (dop),
    .drop_idx (pend_idx),
    .stat     (dstat),
    .hit_idx  (hit_idx),
    .free_idx (free_idx),
    .present  (present)
  );

  // Read-modify-write of one cell. The count follows the bitmap exactly, so it is
  // never zero when a set bit is cleared; the guard only mirrors the rule.
  always_comb begin
    row_old          = row_q[op_lx];
    row_new          = row_q;
    row_new[op_lx]   = op_val;
    live_new         = live_q;
    if (op_val) begin
      live_new = live_q + LIVE_W'(1);
    end else if (live_q != '0) begin
      live_new = live_q - LIVE_W'(1);
    end
  end

  assign do_write = fin && op_use && (op_cmd == CMD_WRITE) && (row_old != op_val);

  // Port steering. Accesses of successive items never overlap: the write-back
  // lands at the edge that returns to idle, before the next read is issued.
  always_comb begin
    row_we    = 1'b0;
    row_re    = 1'b0;
    row_addr  = '0;
    row_wd    = '0;
    live_we   = 1'b0;
    live_re   = 1'b0;
    live_addr = '0;
    live_wd   = '0;
    case (state)
      ST_CLEAR: begin
        row_we    = 1'b1;
        row_addr  = clr_cnt;
        live_we   = (clr_cnt < ROW_AW'(CHUNK_ENTRIES));
        live_addr = clr_cnt[IDX_W-1:0];
      end
      ST_IDLE: begin
        row_re    = accept;
        row_addr  = ROW_AW'({e_sel, ly});
        live_re   = accept;
        live_addr = e_sel;
      end
      ST_CULL: begin
        live_re   = (walk < COUNT_W'(CHUNK_ENTRIES));
        live_addr = walk[IDX_W-1:0];
      end
      ST_ACCESS: begin
        row_we    = do_write;
        row_addr  = op_row;
        row_wd    = row_new;
        live_we   = do_write;
        live_addr = op_idx;
        live_wd   = live_new;
      end
      default: begin
      end
    endcase
  end

  scbg_ram #(
    .WIDTH (CHUNK_SIDE),
    .DEPTH (ROWS)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .re    (row_re),
    .addr  (row_addr),
    .wdata (row_wd),
    .rdata (row_q)
  );

  scbg_ram #(
    .WIDTH (LIVE_W),
    .DEPTH (CHUNK_ENTRIES)
  ) u_live_ram (
    .clk   (clk),
    .we    (live_we),
    .re    (live_re),
    .addr  (live_addr),
    .wdata (live_wd),
    .rdata (live_q)
  );

  // Sequencer, clearing pass and cull walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      walk    <= '0;
      pend    <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + ROW_AW'(1);
          if (clr_cnt == ROW_AW'(ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (req.cmd == CMD_CULL) begin
              state <= ST_CULL;
              walk  <= '0;
              pend  <= 1'b0;
            end else begin
              state <= ST_ACCESS;
            end
          end
        end
        ST_CULL: begin
          if (walk < COUNT_W'(CHUNK_ENTRIES)) begin
            walk <= walk + COUNT_W'(1);
            pend <= 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= ST_ACCESS;
          end
        end
        ST_ACCESS: begin
          if (fin) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd  <= req.cmd;
      op_use  <= req_use;
      op_full <= req_full;
      op_val  <= req.set_value;
      op_idx  <= e_sel;
      op_lx   <= lx;
      op_row  <= ROW_AW'({e_sel, ly});
    end
    if (state == ST_CULL) begin
      pend_idx <= walk[IDX_W-1:0];
    end
  end

  // Output register: a finished item is loaded only into a free slot or one whose result is taken in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_cell   <= op_use && (op_cmd == CMD_READ) && row_old;
      out_status <= op_full;
      out_count  <= present;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.cell_value  = out_cell;
  assign rsp.status      = out_status;
  assign rsp.chunk_count = out_count;

endmodule

/* rtl/core/scbg_checker.sv */
// Port-level checker of the sparse chunked bit grid, bound to the top level.
// Depends on sparse_chunked_bit_grid_assert.svh and the top level's ports.
`include "sparse_chunked_bit_grid_assert.svh"

module scbg_checker #(
  parameter int CHUNK_ENTRIES = 16,
  parameter int COUNT_W       = 5
) (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               cell_value,
  input logic               status,
  input logic [COUNT_W-1:0] chunk_count
);

  // Never more chunks reported than there are slots.
  `SCBG_CHECK_NOW(a_count_bound, clk, rst, rsp_valid, chunk_count <= COUNT_W'(CHUNK_ENTRIES), "chunk count above capacity")

  // A dropped write never returns a set bit.
  `SCBG_CHECK_NOW(a_full_no_bit, clk, rst, rsp_valid && status, !cell_value, "full status with cell value set")

  // One item at a time: ready drops after every accepted item.
  `SCBG_CHECK_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready, "item accepted while busy")

  // The clearing pass keeps the input closed straight after reset.
  `SCBG_CHECK_NOW(a_closed_after_reset, clk, rst, $past(rst), !req_ready, "item accepted during clearing pass")

endmodule

bind sparse_chunked_bit_grid scbg_checker #(
  .CHUNK_ENTRIES (CHUNK_ENTRIES),
  .COUNT_W       (COUNT_W)
) u_scbg_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .cell_value  (rsp.cell_value),
  .status      (rsp.status),
  .chunk_count (rsp.chunk_count)
);

/* test/sparse_chunked_bit_grid_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the sparse chunked bit grid: directed corners, store full and
// random rounds. Depends on scbg_pkg, scbg_req_if, scbg_rsp_if and sparse_chunked_bit_grid.
module sparse_chunked_bit_grid_test;
  import scbg_pkg::*;

  localparam int CHUNK_ENTRIES = CHUNK_ENTRIES_DEF;
  localparam int CHUNK_SIDE    = CHUNK_SIDE_DEF;
  localparam int COORD_BITS    = COORD_BITS_DEF;
  localparam int LOCAL_BITS    = $clog2(CHUNK_SIDE);
  localparam int KEY_BITS      = 2 * (COORD_BITS - LOCAL_BITS);
  localparam int COUNT_W       = $clog2(CHUNK_ENTRIES + 1);
  localparam int CHUNK_W       = COORD_BITS - LOCAL_BITS;

  // The spare command code is a no-operation that still returns a result.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // A cull walks every entry, so this is the longest a single item keeps the block busy.
  localparam int CULL_CYCLES = CHUNK_ENTRIES + 3 + 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 20;
  localparam int ROUNDS      = 5;
  localparam int ROUND_ITEMS = 100;

  typedef struct packed {
    logic               cell_bit;
    logic               full;
    logic [COUNT_W-1:0] count;
  } grid_result_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } cell_pos_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  scbg_req_if req_ch ();
  scbg_rsp_if rsp_ch ();

  sparse_chunked_bit_grid dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // The bench's own copy of the grid: directory, live-cell counts and bitmaps.
  logic                slot_used [CHUNK_ENTRIES];
  logic [KEY_BITS-1:0] slot_key  [CHUNK_ENTRIES];
  int unsigned         slot_live [CHUNK_ENTRIES];
  logic [CHUNK_SIDE-1:0] slot_rows [CHUNK_ENTRIES][CHUNK_SIDE];

  grid_result_t expected_results[$];
  cell_pos_t    lit_cells[$];

  // Chunk coordinates that the random rounds aim at; more of them than there are entries,
  // so that the store fills up and writes are dropped now and then.
  logic signed [CHUNK_W-1:0] pool_cx [POOL_SIZE];
  logic signed [CHUNK_W-1:0] pool_cy [POOL_SIZE];

  int  mismatches  = 0;
  int  cycle_count = 0;
  bit  send_steady = 1'b0;
  bit  take_steady = 1'b0;

  // A generous ceiling on the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sparse_chunked_bit_grid test failed");
      $finish;
    end
  end

  function automatic int find_slot(input logic [KEY_BITS-1:0] key);
    for (int i = 0; i < CHUNK_ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Works out what the grid answers for one accepted item and files the expectation.
  // The chunk key is simply the coordinate with its local bits dropped, which is the
  // floor division for two's complement values.
  task automatic grid_apply(input logic [CMD_W-1:0] op, input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y, input logic v);
    logic [KEY_BITS-1:0] key;
    int                  slot;
    int                  lx;
    int                  ly;
    int                  i;
    grid_result_t        res;
    key  = {x[COORD_BITS-1:LOCAL_BITS], y[COORD_BITS-1:LOCAL_BITS]};
    lx   = int'(x[LOCAL_BITS-1:0]);
    ly   = int'(y[LOCAL_BITS-1:0]);
    res  = '0;
    slot = find_slot(key);
    case (op)
      CMD_READ: begin
        if (slot >= 0) res.cell_bit = slot_rows[slot][ly][lx];
      end
      CMD_WRITE: begin
        if (slot < 0 && v) begin
          // Allocation takes the lowest free entry with a fresh, empty bitmap.
          for (i = 0; i < CHUNK_ENTRIES; i++) begin
            if (!slot_used[i]) break;
          end
          if (i < CHUNK_ENTRIES) begin
            slot            = i;
            slot_used[slot] = 1'b1;
            slot_key[slot]  = key;
            slot_live[slot] = 0;
            for (i = 0; i < CHUNK_SIDE; i++) slot_rows[slot][i] = '0;
          end else begin
            res.full = 1'b1;
          end
        end
        if (slot >= 0 && slot_rows[slot][ly][lx] != v) begin
          slot_rows[slot][ly][lx] = v;
          if (v) begin
            slot_live[slot]++;
          end else if (slot_live[slot] > 0) begin
            slot_live[slot]--;
          end
        end
      end
      CMD_CULL: begin
        for (i = 0; i < CHUNK_ENTRIES; i++) begin
          if (slot_used[i] && slot_live[i] == 0) slot_used[i] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    for (i = 0; i < CHUNK_ENTRIES; i++) begin
      if (slot_used[i]) res.count++;
    end
    expected_results.insert(expected_results.size(), res);
  endtask

  // Presents one item after a random gap and waits for it to be taken. Valid is left
  // high afterwards, so back-to-back items never lower and raise it in the same step.
  task automatic send_item(input logic [CMD_W-1:0] op, input logic signed [COORD_BITS-1:0] x,
                           input logic signed [COORD_BITS-1:0] y, input logic v);
    int        gap;
    cell_pos_t pos;
    gap = send_steady ? 0 : int'($urandom_range(0, 4));
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= op;
    req_ch.x_coord   <= x;
    req_ch.y_coord   <= y;
    req_ch.set_value <= v;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    grid_apply(op, x, y, v);
    // Remember every lit cell, so that a sweep can empty the chunks again later.
    if (op == CMD_WRITE && v) begin
      pos.x = x;
      pos.y = y;
      lit_cells.insert(lit_cells.size(), pos);
    end
  endtask

  // Stops sending and lets every result come home, then allows for a cull still running.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (CULL_CYCLES) @(posedge clk);
  endtask

  // Clears every cell written so far and culls, which leaves the directory empty.
  task automatic sweep_and_cull();
    cell_pos_t pos;
    while (lit_cells.size() != 0) begin
      pos = lit_cells.pop_front();
      send_item(CMD_WRITE, pos.x, pos.y, 1'b0);
    end
    send_item(CMD_CULL, '0, '0, 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  // Reset leaves chunk (0,0) present and empty; the spare code does nothing.
  task automatic test_reset_state();
    send_item(CMD_READ, 16'sd0, 16'sd0, 1'b0);
    send_item(CMD_SPARE, -16'sd32768, 16'sd32767, 1'b1);
  endtask

  // Coordinate extremes, negative chunks, absent chunks and the cull of chunk (0,0).
  task automatic test_corners();
    send_item(CMD_WRITE, 16'sd0, 16'sd0, 1'b1);
    send_item(CMD_READ, 16'sd0, 16'sd0, 1'b0);
    send_item(CMD_WRITE, 16'sd32767, -16'sd32768, 1'b1);
    send_item(CMD_READ, 16'sd32767, -16'sd32768, 1'b1);
    send_item(CMD_READ, -16'sd32768, 16'sd32767, 1'b0);
    send_item(CMD_WRITE, -16'sd1, -16'sd1, 1'b0);
    send_item(CMD_WRITE, -16'sd1, -16'sd1, 1'b1);
    send_item(CMD_WRITE, -16'sd1, -16'sd1, 1'b1);
    send_item(CMD_READ, -16'sd32, -16'sd32, 1'b0);
    send_item(CMD_READ, -16'sd1, -16'sd1, 1'b0);
    send_item(CMD_WRITE, 16'sd0, 16'sd0, 1'b0);
    send_item(CMD_CULL, 16'sd0, 16'sd0, 1'b0);
    send_item(CMD_READ, 16'sd0, 16'sd0, 1'b0);
    sweep_and_cull();
  endtask

  // One more distinct chunk than there are entries: the last write must be dropped.
  task automatic test_store_full();
    for (int k = 0; k <= CHUNK_ENTRIES; k++) begin
      send_item(CMD_WRITE, 16'(k * CHUNK_SIDE + k), 16'(5 * CHUNK_SIDE + 7), 1'b1);
    end
    sweep_and_cull();
  endtask

  // Random rounds over a pool of chunks, with reads, writes, erases, culls and noise.
  task automatic test_random_rounds();
    int                           kind;
    int                           pick;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [LOCAL_BITS-1:0]        lx;
    logic [LOCAL_BITS-1:0]        ly;
    cell_pos_t                    pos;
    for (int round = 0; round < ROUNDS; round++) begin
      send_steady = (round == 1 || round == 3);
      take_steady = (round == 2 || round == 3);
      // The first entries of the pool are fixed: chunk (0,0), chunk (-1,-1) and the chunk extremes.
      pool_cx[0] = '0;
      pool_cy[0] = '0;
      pool_cx[1] = '1;
      pool_cy[1] = '1;
      pool_cx[2] = {1'b1, {(CHUNK_W-1){1'b0}}};
      pool_cy[2] = {1'b0, {(CHUNK_W-1){1'b1}}};
      pool_cx[3] = {1'b0, {(CHUNK_W-1){1'b1}}};
      pool_cy[3] = {1'b1, {(CHUNK_W-1){1'b0}}};
      for (int p = 4; p < POOL_SIZE; p++) begin
        pool_cx[p] = CHUNK_W'($urandom_range(0, (1 << CHUNK_W) - 1));
        pool_cy[p] = CHUNK_W'($urandom_range(0, (1 << CHUNK_W) - 1));
      end
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        kind = int'($urandom_range(0, 99));
        pick = int'($urandom_range(0, POOL_SIZE - 1));
        // Local cells cluster in one corner so that erases and rereads often land.
        lx = LOCAL_BITS'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                              : $urandom_range(0, CHUNK_SIDE - 1));
        ly = LOCAL_BITS'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                              : $urandom_range(0, CHUNK_SIDE - 1));
        x  = {pool_cx[pick], lx};
        y  = {pool_cy[pick], ly};
        if (kind < 40) begin
          send_item(CMD_WRITE, x, y, $urandom_range(0, 9) < 6);
        end else if (kind < 75) begin
          send_item(CMD_READ, x, y, 1'($urandom_range(0, 1)));
        end else if (kind < 80) begin
          send_item(CMD_CULL, x, y, 1'($urandom_range(0, 1)));
        end else if (kind < 85) begin
          send_item(CMD_SPARE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                    1'($urandom_range(0, 1)));
        end else if (kind < 90) begin
          send_item($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, COORD_BITS'($urandom),
                    COORD_BITS'($urandom), 1'($urandom_range(0, 1)));
        end else if (lit_cells.size() != 0) begin
          pos = lit_cells[$urandom_range(0, lit_cells.size() - 1)];
          send_item(CMD_WRITE, pos.x, pos.y, 1'b0);
        end else begin
          send_item(CMD_READ, x, y, 1'b0);
        end
      end
      // Pause between rounds until the block has nothing left to answer.
      wait_drained();
      if (round % 2 == 1) sweep_and_cull();
    end
    send_steady = 1'b0;
    take_steady = 1'b0;
  endtask

  // Takes results after random stalls and compares each with the oldest expectation.
  initial begin : result_checker
    int           stall;
    grid_result_t got;
    grid_result_t want;
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = take_steady ? 0 : int'($urandom_range(0, 4));
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      got.cell_bit = rsp_ch.cell_value;
      got.full     = rsp_ch.status;
      got.count    = rsp_ch.chunk_count;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: cell %0b status %0b count %0d",
                   got.cell_bit, got.full, got.count);
        end
      end else begin
        want = expected_results.pop_front();
        if (got.cell_bit !== want.cell_bit || got.full !== want.full ||
            got.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"result mismatch: expected cell %0b status %0b count %0d, ",
                      "got cell %0b status %0b count %0d"},
                     want.cell_bit, want.full, want.count,
                     got.cell_bit, got.full, got.count);
          end
        end
      end
    end
  end

  initial begin
    // The bench's grid starts as the block does after reset: only chunk (0,0) present.
    for (int i = 0; i < CHUNK_ENTRIES; i++) begin
      slot_used[i] = (i == 0);
      slot_key[i]  = '0;
      slot_live[i] = 0;
      for (int r = 0; r < CHUNK_SIDE; r++) slot_rows[i][r] = '0;
    end
    req_ch.valid     = 1'b0;
    req_ch.cmd       = CMD_READ;
    req_ch.x_coord   = '0;
    req_ch.y_coord   = '0;
    req_ch.set_value = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // The block clears its bitmap memory after reset; the first item simply waits on ready.
    test_reset_state();
    test_corners();
    test_store_full();
    test_random_rounds();
    wait_drained();
    if (mismatches == 0) begin
      $display("sparse_chunked_bit_grid test passed");
    end else begin
      $display("sparse_chunked_bit_grid test failed");
    end
    $finish;
  end

endmodule
